/* hdl/xlbm_pkg.sv */
`default_nettype none
package xlbm_pkg;

   localparam int VEC_BITS_DEF = 31;
   localparam int VALUE_W      = 31;
   localparam int MAX_XOR_W    = 31;
   localparam int RANK_W       = 5;

   typedef struct packed {
      logic valid;
      logic added;
   } stage_ctl_type;

endpackage
`default_nettype wire

/* hdl/xlbm_if.sv */
`default_nettype none
interface xlbm_req_if import xlbm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface xlbm_rsp_if import xlbm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [MAX_XOR_W-1:0] max_xor;
   logic                 was_independent;
   logic [RANK_W-1:0]    rank;

   modport source (output valid, output max_xor, output was_independent, output rank,
                   input ready);
   modport sink (input valid, input max_xor, input was_independent, input rank,
                 output ready);
endinterface
`default_nettype wire

/* hdl/xor_linear_basis_max_core.sv */
// A request passes through the basis cell chain, one cell per leading bit, top bit first,
// then the response register. Throughput: one request per cycle while no response is held;
// a held response stalls the whole cell chain and the request side together.
// Reset (synchronous): clears the chain valid bits, every slot-filled flag and the rank;
// the block accepts requests in the cycle after reset is released.
`default_nettype none
module xor_linear_basis_max_core import xlbm_pkg::*; #(
   parameter int VEC_BITS = VEC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   xlbm_req_if.sink     req_bus,
   xlbm_rsp_if.source   rsp_bus
);

   localparam int RANK_CNT_W = $clog2(VEC_BITS + 1);

   stage_ctl_type       chain_ctl  [0:VEC_BITS];
   logic [VEC_BITS-1:0] chain_vec  [0:VEC_BITS];
   logic [VEC_BITS-1:0] chain_best [0:VEC_BITS];

   logic                     advance;
   logic [VALUE_W+VEC_BITS-1:0]   value_wide;
   logic [MAX_XOR_W+VEC_BITS-1:0] max_wide;
   logic [RANK_W+RANK_CNT_W-1:0]  rank_wide;

   logic [RANK_CNT_W-1:0] rank_ff, rank_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MAX_XOR_W-1:0]  rsp_max_ff;
   logic                  rsp_indep_ff;
   logic [RANK_W-1:0]     rsp_rank_ff;

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   assign value_wide       = {{VEC_BITS{1'b0}}, req_bus.value};
   assign chain_ctl[0]     = '{valid: req_bus.valid, added: 1'b0};
   assign chain_vec[0]     = value_wide[VEC_BITS-1:0];
   assign chain_best[0]    = '0;

   for (genvar k = 0; k < VEC_BITS; k++) begin : g_cell
      xlbm_cell #(
         .VEC_BITS (VEC_BITS),
         .BIT_POS  (VEC_BITS - 1 - k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .up_ctl  (chain_ctl[k]),
         .up_vec  (chain_vec[k]),
         .up_best (chain_best[k]),
         .dn_ctl  (chain_ctl[k+1]),
         .dn_vec  (chain_vec[k+1]),
         .dn_best (chain_best[k+1])
      );
   end

   always_comb begin
      rank_in      = rank_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = chain_ctl[VEC_BITS].valid;
         if (chain_ctl[VEC_BITS].valid) begin
            rank_in = rank_ff + RANK_CNT_W'(chain_ctl[VEC_BITS].added);
         end
      end
      max_wide  = {{MAX_XOR_W{1'b0}}, chain_best[VEC_BITS]};
      rank_wide = {{RANK_W{1'b0}}, rank_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rank_ff      <= rank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && chain_ctl[VEC_BITS].valid) begin
         rsp_max_ff   <= max_wide[MAX_XOR_W-1:0];
         rsp_indep_ff <= chain_ctl[VEC_BITS].added;
         rsp_rank_ff  <= rank_wide[RANK_W-1:0];
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.max_xor         = rsp_max_ff;
   assign rsp_bus.was_independent = rsp_indep_ff;
   assign rsp_bus.rank            = rsp_rank_ff;

   logic unused_tail;
   assign unused_tail = ^chain_vec[VEC_BITS];

endmodule
`default_nettype wire

/* hdl/xlbm_cell.sv */
`default_nettype none
module xlbm_cell import xlbm_pkg::*; #(
   parameter int VEC_BITS = VEC_BITS_DEF,
   parameter int BIT_POS  = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  stage_ctl_type       up_ctl,
   input  logic [VEC_BITS-1:0] up_vec,
   input  logic [VEC_BITS-1:0] up_best,
   output stage_ctl_type       dn_ctl,
   output logic [VEC_BITS-1:0] dn_vec,
   output logic [VEC_BITS-1:0] dn_best
);

   logic [VEC_BITS-1:0] slot_vec_ff, slot_vec_in;
   logic                filled_ff, filled_in;
   stage_ctl_type       ctl_ff, ctl_in;
   logic [VEC_BITS-1:0] vec_ff, vec_in;
   logic [VEC_BITS-1:0] best_ff, best_in;
   logic                hit, store, reduce;

   always_comb begin
      hit          = up_ctl.valid && !up_ctl.added && up_vec[BIT_POS];
      store        = hit && !filled_ff;
      reduce       = hit && filled_ff;
      slot_vec_in  = store ? up_vec : slot_vec_ff;
      filled_in    = filled_ff || store;
      vec_in       = reduce ? (up_vec ^ slot_vec_ff) : up_vec;
      ctl_in.valid = up_ctl.valid;
      ctl_in.added = up_ctl.added || store;
      // greedy max: slot i leads at bit i, so it helps only when that bit is clear
      best_in      = (filled_in && !up_best[BIT_POS]) ? (up_best ^ slot_vec_in) : up_best;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff    <= '0;
         filled_ff <= 1'b0;
      end else if (advance) begin
         ctl_ff    <= ctl_in;
         filled_ff <= filled_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vec_ff      <= vec_in;
         best_ff     <= best_in;
         slot_vec_ff <= slot_vec_in;
      end
   end

   assign dn_ctl  = ctl_ff;
   assign dn_vec  = vec_ff;
   assign dn_best = best_ff;

endmodule
`default_nettype wire

/* hdl/xlbm_checker.sv */
`default_nettype none
module xlbm_checker import xlbm_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [MAX_XOR_W-1:0] rsp_max_xor,
   input wire logic                 rsp_was_independent,
   input wire logic [RANK_W-1:0]    rsp_rank
);

   logic [RANK_W-1:0]    last_rank_ff;
   logic [MAX_XOR_W-1:0] last_max_ff;
   logic                 rsp_take;

   assign rsp_take = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_rank_ff <= '0;
         last_max_ff  <= '0;
      end else if (rsp_take) begin
         last_rank_ff <= rsp_rank;
         last_max_ff  <= rsp_max_xor;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_max_xor) && $stable(rsp_rank))
      else $error("response changed while stalled");

   a_rank_step: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> rsp_rank == last_rank_ff + RANK_W'(rsp_was_independent))
      else $error("rank does not follow the independent flag");

   a_max_grows: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> rsp_max_xor >= last_max_ff)
      else $error("maximum xor fell");

   a_empty_basis: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_rank == '0) == (rsp_max_xor == '0))
      else $error("maximum xor disagrees with rank");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind xor_linear_basis_max_core xlbm_checker u_xlbm_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_max_xor         (rsp_bus.max_xor),
   .rsp_was_independent (rsp_bus.was_independent),
   .rsp_rank            (rsp_bus.rank)
);
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
module testbench import xlbm_pkg::*; ();

   localparam int NBITS = VEC_BITS_DEF;

   typedef struct packed {
      logic [MAX_XOR_W-1:0] max_xor;
      logic                 was_independent;
      logic [RANK_W-1:0]    rank;
   } basis_report_type;

   typedef struct {
      logic [VALUE_W-1:0] value;
      bit                 drain;
   } vector_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   xlbm_req_if req_bus ();
   xlbm_rsp_if rsp_bus ();

   xor_linear_basis_max_core #(.VEC_BITS(NBITS)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   vector_item_type    vector_queue[$];
   basis_report_type   basis_reports[$];
   logic [NBITS-1:0]   span_vec[NBITS] = '{default: '0};
   int                 span_rank = 0;
   int                 accepted_count = 0;
   int                 checked_count = 0;
   int                 error_count = 0;
   int                 send_gap;
   int                 send_calm = 0;
   int                 stall_left;
   int                 stall_calm = 0;

   always #6 clock = ~clock;

   // mostly short, a few long, with quiet runs where nothing idles
   function automatic int pick_gap(ref int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   function automatic basis_report_type insert_and_max(input logic [VALUE_W-1:0] raw);
      logic [NBITS-1:0] v;
      logic [NBITS-1:0] best;
      basis_report_type rep;
      bit               added;
      v = raw[NBITS-1:0];
      added = 1'b0;
      best = '0;
      for (int i = NBITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            if (span_vec[i] != '0) begin
               v ^= span_vec[i];
            end else begin
               span_vec[i] = v;
               span_rank++;
               added = 1'b1;
               break;
            end
         end
      end
      for (int i = NBITS - 1; i >= 0; i--) begin
         if ((best ^ span_vec[i]) > best) best ^= span_vec[i];
      end
      rep.max_xor = best;
      rep.was_independent = added;
      rep.rank = span_rank[RANK_W-1:0];
      return rep;
   endfunction

   // request driver
   always @(posedge clock) begin
      vector_item_type next_item;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.value <= '0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            basis_reports.push_back(insert_and_max(req_bus.value));
            accepted_count++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (vector_queue.size() != 0 &&
                         (!vector_queue[0].drain || checked_count == accepted_count)) begin
               next_item = vector_queue.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.value <= next_item.value;
               send_gap = pick_gap(send_calm);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      basis_report_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (basis_reports.size() == 0) begin
               $display("%0t: unexpected response: max_xor %h was_independent %b rank %0d",
                        $time, rsp_bus.max_xor, rsp_bus.was_independent, rsp_bus.rank);
               error_count++;
            end else begin
               want = basis_reports.pop_front();
               checked_count <= checked_count + 1;
               if (rsp_bus.max_xor !== want.max_xor) begin
                  $display("%0t: max_xor mismatch: expected %h, actual %h",
                           $time, want.max_xor, rsp_bus.max_xor);
                  error_count++;
               end
               if (rsp_bus.was_independent !== want.was_independent) begin
                  $display("%0t: was_independent mismatch: expected %b, actual %b",
                           $time, want.was_independent, rsp_bus.was_independent);
                  error_count++;
               end
               if (rsp_bus.rank !== want.rank) begin
                  $display("%0t: rank mismatch: expected %0d, actual %0d",
                           $time, want.rank, rsp_bus.rank);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = pick_gap(stall_calm);
         end
      end
   end

   initial begin
      logic [VALUE_W-1:0] directed[$];
      logic [NBITS-1:0]   gens[$];
      logic [NBITS-1:0]   g;
      logic [VALUE_W-1:0] v;
      vector_item_type    item;
      int                 w;
      int                 r;

      directed = '{31'h0000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h0000_0000,
                   31'h4000_0000, 31'h3FFF_FFFF, 31'h0000_0001, 31'h0000_0001,
                   31'h2AAA_AAAA, 31'h5555_5555, 31'h0001_0000, 31'h7FFE_FFFF,
                   31'h1234_5678, 31'h0000_0002, 31'h0000_0000, 31'h4000_0001};
      foreach (directed[i]) begin
         item.value = directed[i];
         item.drain = (i == 4);
         vector_queue.push_back(item);
      end

      // random part: combinations over a slowly growing generator set, so the
      // rank climbs gradually and most requests exercise the reduction path
      for (int n = 0; n < 950; n++) begin
         if (n % 30 == 0) begin
            w = $urandom_range(1, NBITS);
            g = NBITS'($urandom() & ((32'h1 << w) - 1));
            if ($urandom_range(0, 1)) g[w-1] = 1'b1;
            if (g == '0) g[w-1] = 1'b1;
            gens.push_back(g);
         end
         r = $urandom_range(0, 99);
         if (r < 3) begin
            v = '0;
         end else if (r < 5) begin
            v = VALUE_W'($urandom());
         end else if (r < 9) begin
            v = '0;
            v[$urandom_range(0, VALUE_W - 1)] = 1'b1;
         end else begin
            v = '0;
            foreach (gens[j]) if ($urandom_range(0, 1)) v ^= gens[j];
         end
         item.value = v;
         item.drain = (n == 0 || n == 480);
         vector_queue.push_back(item);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (vector_queue.size() != 0 || req_bus.valid || checked_count != accepted_count)
         @(posedge clock);
      repeat (NBITS + 20) @(posedge clock);

      if (error_count == 0 && basis_reports.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
